// File: rtl/bis_pkg.sv
// ---------------------------------------------------------------------------
// bis_pkg
// Shared types and constants of the bilinear image scaler.
// ---------------------------------------------------------------------------
package bis_pkg;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int DIM_W      = 10;
   localparam int SCALE_W    = 24;
   localparam int COORD_W    = 9;
   localparam int PIXEL_W    = 8;
   localparam int FRAC_W     = 16;
   localparam int PROD_W     = COORD_W + SCALE_W;
   localparam int INT_W      = PROD_W - FRAC_W;
   localparam int WEIGHT_W   = FRAC_W + 1;
   localparam int ROW_W      = PIXEL_W + FRAC_W;
   localparam int ACC_W      = ROW_W + WEIGHT_W;

   localparam logic [WEIGHT_W-1:0] ONE_Q16 = WEIGHT_W'(65536);

   localparam logic [DIM_W-1:0]   SRC_WIDTH_RST  = DIM_W'(512);
   localparam logic [DIM_W-1:0]   SRC_HEIGHT_RST = DIM_W'(512);
   localparam logic [SCALE_W-1:0] INV_SCALE_RST  = SCALE_W'(43691);

   localparam logic [1:0] REG_SRC_WIDTH  = 2'd0;
   localparam logic [1:0] REG_SRC_HEIGHT = 2'd1;
   localparam logic [1:0] REG_INV_SCALE  = 2'd2;

   localparam logic OP_LOAD    = 1'b0;
   localparam logic OP_COMPUTE = 1'b1;

   typedef struct packed {
      logic [DIM_W-1:0]   src_width;
      logic [DIM_W-1:0]   src_height;
      logic [SCALE_W-1:0] inv_scale;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAP,
      ST_RD0,
      ST_RD1,
      ST_RD2,
      ST_RD3,
      ST_MIX0,
      ST_MIX1
   } state_type;

endpackage

// File: rtl/bis_ram.sv
// ---------------------------------------------------------------------------
// bis_ram
// Single-port synchronous RAM with registered read data.
// ---------------------------------------------------------------------------
module bis_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 262144
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/bis_csr.sv
// ---------------------------------------------------------------------------
// bis_csr
// APB register file: source width, source height and inverse scale.
// ---------------------------------------------------------------------------
module bis_csr
   import bis_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic [1:0] reg_index;
   logic       wr_transfer;

   assign reg_index   = paddr[3:2];
   assign wr_transfer = psel && penable && pwrite;
   assign pready      = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_transfer) begin
         case (reg_index)
            REG_SRC_WIDTH: begin
               cfg_in.src_width = pwdata[DIM_W-1:0];
            end
            REG_SRC_HEIGHT: begin
               cfg_in.src_height = pwdata[DIM_W-1:0];
            end
            REG_INV_SCALE: begin
               cfg_in.inv_scale = pwdata[SCALE_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         REG_SRC_WIDTH:  prdata = CSR_DATA_W'(cfg_ff.src_width);
         REG_SRC_HEIGHT: prdata = CSR_DATA_W'(cfg_ff.src_height);
         REG_INV_SCALE:  prdata = CSR_DATA_W'(cfg_ff.inv_scale);
         default:        prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.src_width  <= SRC_WIDTH_RST;
         cfg_ff.src_height <= SRC_HEIGHT_RST;
         cfg_ff.inv_scale  <= INV_SCALE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: rtl/bilinear_image_scaler.sv
// ---------------------------------------------------------------------------
// bilinear_image_scaler
// Grayscale bilinear scaler over a frame store of source pixels.
// ---------------------------------------------------------------------------
// A load transfer writes one pixel into the frame store in the cycle it is
// taken, if its coordinates lie inside the store, and keeps busy low, so
// loads stream at one per cycle while no compute is running. A compute
// transfer raises busy until its result shows on rsp_strobe; the next
// transfer can be taken in that same cycle, so computed pixels do not
// overlap. The accepting cycle registers the scaled coordinates, then come
// coordinate clamping, the four neighbour reads through the single port of
// the frame store, blending and the result register. Results cannot be held
// off by the receiver. The frame store needs no clearing after reset; a read
// of a pixel never loaded returns an arbitrary value.
// ---------------------------------------------------------------------------
module bilinear_image_scaler
   import bis_pkg::*;
#(
   parameter int MAX_WIDTH  = 512,
   parameter int MAX_HEIGHT = 512
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic                  req_operation,
   input  logic [COORD_W-1:0]    req_coord_x,
   input  logic [COORD_W-1:0]    req_coord_y,
   input  logic [PIXEL_W-1:0]    req_pixel_value,
   output logic                  rsp_strobe,
   output logic [PIXEL_W-1:0]    rsp_out_pixel,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = $clog2(DEPTH);
   localparam int XW    = $clog2(MAX_WIDTH);
   localparam int YW    = $clog2(MAX_HEIGHT);

   cfg_type cfg;

   state_type state_ff, state_in;

   logic                 accept;
   logic                 load_ok;
   logic                 ram_we;
   logic [AW-1:0]        ram_addr;
   logic [PIXEL_W-1:0]   ram_rdata;
   logic [XW-1:0]        rd_x;
   logic [YW-1:0]        rd_y;
   logic                 cap_prod, cap_map, cap_p00, cap_top, cap_p01, cap_bot, emit;

   logic [XW-1:0]        wlast;
   logic [YW-1:0]        hlast;
   logic [INT_W-1:0]     ix, iy;

   logic [PROD_W-1:0]    sx_ff, sx_in, sy_ff, sy_in;
   logic [XW-1:0]        x0_ff, x0_in, x1_ff, x1_in;
   logic [YW-1:0]        y0_ff, y0_in, y1_ff, y1_in;
   logic [FRAC_W-1:0]    fx_ff, fx_in, fy_ff, fy_in;
   logic [PIXEL_W-1:0]   p00_ff, p00_in, p01_ff, p01_in;
   logic [ROW_W-1:0]     top_ff, top_in, bot_ff, bot_in;
   logic [ACC_W-1:0]     part_ff, part_in;
   logic [ACC_W-1:0]     acc;
   logic [WEIGHT_W-1:0]  wx0, wy0;
   logic [WEIGHT_W+PIXEL_W-1:0] row_sum;

   logic                 rsp_strobe_ff, rsp_strobe_in;
   logic [PIXEL_W-1:0]   rsp_pixel_ff, rsp_pixel_in;

   bis_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   bis_ram #(
      .WIDTH (PIXEL_W),
      .DEPTH (DEPTH)
   ) u_frame_store (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (req_pixel_value),
      .rdata (ram_rdata)
   );

   assign busy    = (state_ff != ST_IDLE);
   assign accept  = start && !busy;
   assign load_ok = (32'(req_coord_x) < MAX_WIDTH) && (32'(req_coord_y) < MAX_HEIGHT);

   always_comb begin
      state_in = state_ff;
      ram_we   = 1'b0;
      ram_addr = AW'(32'(req_coord_y) * MAX_WIDTH + 32'(req_coord_x));
      rd_x     = x0_ff;
      rd_y     = y0_ff;
      cap_prod = 1'b0;
      cap_map  = 1'b0;
      cap_p00  = 1'b0;
      cap_top  = 1'b0;
      cap_p01  = 1'b0;
      cap_bot  = 1'b0;
      emit     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_operation == OP_COMPUTE) begin
                  cap_prod = 1'b1;
                  state_in = ST_MAP;
               end else begin
                  ram_we = load_ok;
               end
            end
         end
         ST_MAP: begin
            cap_map  = 1'b1;
            state_in = ST_RD0;
         end
         ST_RD0: begin
            rd_x     = x0_ff;
            rd_y     = y0_ff;
            ram_addr = AW'(32'(rd_y) * MAX_WIDTH + 32'(rd_x));
            state_in = ST_RD1;
         end
         ST_RD1: begin
            rd_x     = x1_ff;
            rd_y     = y0_ff;
            ram_addr = AW'(32'(rd_y) * MAX_WIDTH + 32'(rd_x));
            cap_p00  = 1'b1;
            state_in = ST_RD2;
         end
         ST_RD2: begin
            rd_x     = x0_ff;
            rd_y     = y1_ff;
            ram_addr = AW'(32'(rd_y) * MAX_WIDTH + 32'(rd_x));
            cap_top  = 1'b1;
            state_in = ST_RD3;
         end
         ST_RD3: begin
            rd_x     = x1_ff;
            rd_y     = y1_ff;
            ram_addr = AW'(32'(rd_y) * MAX_WIDTH + 32'(rd_x));
            cap_p01  = 1'b1;
            state_in = ST_MIX0;
         end
         ST_MIX0: begin
            cap_bot  = 1'b1;
            state_in = ST_MIX1;
         end
         ST_MIX1: begin
            emit     = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cfg.src_width == '0) begin
         wlast = '0;
      end else if (32'(cfg.src_width) > MAX_WIDTH) begin
         wlast = XW'(MAX_WIDTH - 1);
      end else begin
         wlast = XW'(cfg.src_width - DIM_W'(1));
      end
      if (cfg.src_height == '0) begin
         hlast = '0;
      end else if (32'(cfg.src_height) > MAX_HEIGHT) begin
         hlast = YW'(MAX_HEIGHT - 1);
      end else begin
         hlast = YW'(cfg.src_height - DIM_W'(1));
      end
   end

   assign ix      = sx_ff[PROD_W-1:FRAC_W];
   assign iy      = sy_ff[PROD_W-1:FRAC_W];
   assign wx0     = ONE_Q16 - WEIGHT_W'(fx_ff);
   assign wy0     = ONE_Q16 - WEIGHT_W'(fy_ff);
   assign row_sum = (WEIGHT_W+PIXEL_W)'(ram_rdata) * (WEIGHT_W+PIXEL_W)'(fx_ff);
   assign acc     = part_ff + ACC_W'(bot_ff) * ACC_W'(fy_ff);

   always_comb begin
      sx_in        = sx_ff;
      sy_in        = sy_ff;
      x0_in        = x0_ff;
      x1_in        = x1_ff;
      y0_in        = y0_ff;
      y1_in        = y1_ff;
      fx_in        = fx_ff;
      fy_in        = fy_ff;
      p00_in       = p00_ff;
      p01_in       = p01_ff;
      top_in       = top_ff;
      bot_in       = bot_ff;
      part_in      = part_ff;
      rsp_pixel_in = rsp_pixel_ff;
      if (cap_prod) begin
         sx_in = PROD_W'(req_coord_x) * PROD_W'(cfg.inv_scale);
         sy_in = PROD_W'(req_coord_y) * PROD_W'(cfg.inv_scale);
      end
      if (cap_map) begin
         fx_in = sx_ff[FRAC_W-1:0];
         fy_in = sy_ff[FRAC_W-1:0];
         if (ix >= INT_W'(wlast)) begin
            x0_in = wlast;
            x1_in = wlast;
         end else begin
            x0_in = XW'(ix);
            x1_in = XW'(ix + INT_W'(1));
         end
         if (iy >= INT_W'(hlast)) begin
            y0_in = hlast;
            y1_in = hlast;
         end else begin
            y0_in = YW'(iy);
            y1_in = YW'(iy + INT_W'(1));
         end
      end
      if (cap_p00) begin
         p00_in = ram_rdata;
      end
      if (cap_top) begin
         top_in = ROW_W'((WEIGHT_W+PIXEL_W)'(p00_ff) * (WEIGHT_W+PIXEL_W)'(wx0) + row_sum);
      end
      if (cap_p01) begin
         p01_in  = ram_rdata;
         part_in = ACC_W'(top_ff) * ACC_W'(wy0);
      end
      if (cap_bot) begin
         bot_in = ROW_W'((WEIGHT_W+PIXEL_W)'(p01_ff) * (WEIGHT_W+PIXEL_W)'(wx0) + row_sum);
      end
      if (emit) begin
         rsp_pixel_in = acc[2*FRAC_W +: PIXEL_W];
      end
   end

   assign rsp_strobe_in = emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      sx_ff        <= sx_in;
      sy_ff        <= sy_in;
      x0_ff        <= x0_in;
      x1_ff        <= x1_in;
      y0_ff        <= y0_in;
      y1_ff        <= y1_in;
      fx_ff        <= fx_in;
      fy_ff        <= fy_in;
      p00_ff       <= p00_in;
      p01_ff       <= p01_in;
      top_ff       <= top_in;
      bot_ff       <= bot_in;
      part_ff      <= part_in;
      rsp_pixel_ff <= rsp_pixel_in;
   end

   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_out_pixel = rsp_pixel_ff;

endmodule

// File: rtl/bis_checker.sv
// ---------------------------------------------------------------------------
// bis_checker
// Port-level checks of the scaler's command and result timing.
// ---------------------------------------------------------------------------
module bis_checker
   import bis_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic req_operation,
   input logic rsp_strobe,
   input logic pready
);

   logic accept;

   assign accept = start && !busy;

   a_pready_high: assert property (@(posedge clock) disable iff (reset) pready)
      else $error("pready dropped");

   a_compute_busy: assert property (@(posedge clock) disable iff (reset)
      accept && (req_operation == OP_COMPUTE) |=> busy)
      else $error("compute transfer did not raise busy");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      accept && (req_operation == OP_LOAD) |=> !busy)
      else $error("load transfer raised busy");

   a_compute_result: assert property (@(posedge clock) disable iff (reset)
      accept && (req_operation == OP_COMPUTE) |-> ##8 rsp_strobe)
      else $error("compute result missing");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe repeated");

endmodule

bind bilinear_image_scaler bis_checker u_bis_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .req_operation (req_operation),
   .rsp_strobe    (rsp_strobe),
   .pready        (pready)
);
